// ===== hw/rtl/kthrr_pkg.sv =====
// Shared types and codes for the kth-remaining removal core.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package kthrr_pkg;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_DONE = 4'b0100,
      ST_RESP = 4'b1000
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // transaction accepted this cycle
      logic walk;      // one tree level this cycle
      logic capture;   // commit counts and load the response
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic item_error;   // request at the port is out of range or list full
      logic last_level;   // current node is a leaf
   } dp_stat_type;

endpackage

// ===== hw/rtl/kthrr_datapath.sv =====
// Datapath: count tree memory, value memory, walk registers and response registers.
// Depends on kthrr_pkg; sequenced by kthrr_ctrl.
`timescale 1ns / 1ps

module kthrr_datapath #(
   parameter int CAPACITY    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kthrr_pkg::ctl_cmd_type            cmd,
   output kthrr_pkg::dp_stat_type            stat,
   input  logic                              req_opcode,
   input  logic [VALUE_WIDTH-1:0]            req_append_value,
   input  logic [$clog2(CAPACITY+1)-1:0]     req_position,
   output logic [VALUE_WIDTH-1:0]            rsp_removed_value,
   output logic [$clog2(CAPACITY)-1:0]       rsp_removed_slot,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_remaining_count,
   output logic [1:0]                        rsp_status
);

   localparam int CW        = $clog2(CAPACITY + 1);
   localparam int SW        = $clog2(CAPACITY);
   localparam int DEPTH     = SW;
   localparam int LEAVES    = 1 << DEPTH;
   localparam int NW        = DEPTH + 1;
   localparam int TREE_SIZE = 2 * LEAVES;

   logic [CW-1:0]          tree_mem [TREE_SIZE];
   logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];

   logic                   op_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [CW-1:0]          k_ff;
   logic [CW-1:0]          cnt_ff;
   logic [NW-1:0]          node_ff;
   logic [SW-1:0]          lo_ff;
   logic [SW-1:0]          half_ff;
   logic [SW-1:0]          tgt_ff;
   logic [CW-1:0]          appended_ff;
   logic [CW-1:0]          present_ff;
   logic [CW-1:0]          tree_rd_ff;
   logic [VALUE_WIDTH-1:0] value_rd_ff;

   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [SW-1:0]          rsp_slot_ff;
   logic [CW-1:0]          rsp_count_ff;
   logic [1:0]             rsp_status_ff;

   logic                   is_remove;
   logic                   last;
   logic [CW-1:0]          rd_cnt;
   logic                   go_right;
   logic [NW-1:0]          node_in;
   logic [CW-1:0]          cnt_in;
   logic [CW-1:0]          k_in;
   logic [SW-1:0]          lo_in;
   logic [CW-1:0]          wr_data;
   logic                   tree_rd_en;
   logic [NW-1:0]          tree_rd_addr;
   logic                   item_error;

   assign is_remove = (op_ff == kthrr_pkg::OP_REMOVE);
   assign last      = node_ff[DEPTH];

   // Nodes whose leftmost slot lies beyond the fill count were never written.
   assign rd_cnt   = (CW'(lo_ff) < appended_ff) ? tree_rd_ff : '0;
   assign go_right = is_remove ? !(rd_cnt >= k_ff) : |(tgt_ff & half_ff);
   assign node_in  = {node_ff[DEPTH-1:0], go_right};
   assign cnt_in   = go_right ? (cnt_ff - rd_cnt) : rd_cnt;
   assign k_in     = go_right ? (k_ff - rd_cnt) : k_ff;
   assign lo_in    = go_right ? (lo_ff | half_ff) : lo_ff;
   assign wr_data  = is_remove ? (cnt_ff - CW'(1)) : (rd_cnt + CW'(1));

   assign item_error = (req_opcode == kthrr_pkg::OP_APPEND)
                     ? (appended_ff >= CW'(CAPACITY))
                     : ((req_position == '0) || (req_position > present_ff));

   assign stat.item_error = item_error;
   assign stat.last_level = last;

   // Append reads the path node itself; remove reads the left child.
   always_comb begin
      tree_rd_en   = 1'b0;
      tree_rd_addr = '0;
      if (cmd.load) begin
         tree_rd_en   = 1'b1;
         tree_rd_addr = (req_opcode == kthrr_pkg::OP_REMOVE) ? NW'(2) : NW'(1);
      end else if (cmd.walk && !last) begin
         if (is_remove) begin
            tree_rd_en   = !node_in[DEPTH];
            tree_rd_addr = {node_in[DEPTH-1:0], 1'b0};
         end else begin
            tree_rd_en   = 1'b1;
            tree_rd_addr = node_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         tree_mem[node_ff] <= wr_data;
      end
      if (tree_rd_en) begin
         tree_rd_ff <= tree_mem[tree_rd_addr];
      end
      if (cmd.walk && last) begin
         if (is_remove) begin
            value_rd_ff <= value_mem[node_ff[SW-1:0]];
         end else begin
            value_mem[tgt_ff] <= val_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         appended_ff <= '0;
         present_ff  <= '0;
      end else if (cmd.capture) begin
         if (is_remove) begin
            present_ff <= present_ff - CW'(1);
         end else begin
            present_ff  <= present_ff + CW'(1);
            appended_ff <= appended_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         val_ff  <= req_append_value;
         k_ff    <= req_position;
         cnt_ff  <= present_ff;
         node_ff <= NW'(1);
         lo_ff   <= '0;
         half_ff <= SW'(LEAVES / 2);
         tgt_ff  <= appended_ff[SW-1:0];
         if (item_error) begin
            rsp_value_ff  <= '0;
            rsp_slot_ff   <= '0;
            rsp_count_ff  <= present_ff;
            rsp_status_ff <= (req_opcode == kthrr_pkg::OP_APPEND)
                           ? kthrr_pkg::STATUS_FULL : kthrr_pkg::STATUS_RANGE;
         end
      end else if (cmd.walk && !last) begin
         node_ff <= node_in;
         cnt_ff  <= cnt_in;
         k_ff    <= k_in;
         lo_ff   <= lo_in;
         half_ff <= half_ff >> 1;
      end
      if (cmd.capture) begin
         rsp_value_ff  <= is_remove ? value_rd_ff : '0;
         rsp_slot_ff   <= is_remove ? node_ff[SW-1:0] : '0;
         rsp_count_ff  <= is_remove ? (present_ff - CW'(1)) : (present_ff + CW'(1));
         rsp_status_ff <= kthrr_pkg::STATUS_OK;
      end
   end

   assign rsp_removed_value   = rsp_value_ff;
   assign rsp_removed_slot    = rsp_slot_ff;
   assign rsp_remaining_count = rsp_count_ff;
   assign rsp_status          = rsp_status_ff;

   a_present_le_appended: assert property (@(posedge clock) disable iff (reset)
      present_ff <= appended_ff)
      else $error("present count exceeds fill count");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      appended_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_rank_in_node: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && is_remove) |-> (k_ff != '0) && (k_ff <= cnt_ff))
      else $error("rank left the current subtree during descent");

   a_node_filled: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && is_remove) |-> (CW'(lo_ff) < appended_ff))
      else $error("descent entered a subtree with no appended slot");

endmodule

// ===== hw/rtl/kthrr_ctrl.sv =====
// Controller: sequences accept, tree walk, commit and response handshake.
// Depends on kthrr_pkg; drives kthrr_datapath through ctl_cmd_type.
`timescale 1ns / 1ps

module kthrr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  kthrr_pkg::dp_stat_type stat,
   output kthrr_pkg::ctl_cmd_type cmd
);

   kthrr_pkg::ctl_state_type state_ff;
   kthrr_pkg::ctl_state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.walk    = 1'b0;
      cmd.capture = 1'b0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         kthrr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.item_error ? kthrr_pkg::ST_RESP : kthrr_pkg::ST_WALK;
            end
         end
         kthrr_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.last_level) begin
               state_in = kthrr_pkg::ST_DONE;
            end
         end
         kthrr_pkg::ST_DONE: begin
            cmd.capture = 1'b1;
            state_in    = kthrr_pkg::ST_RESP;
         end
         kthrr_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = kthrr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kthrr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kthrr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/kth_remaining_removal_core.sv =====
// Sequence: an accepted transaction walks the tree (ST_WALK), commits (ST_DONE) and then
//   responds (ST_RESP); rejected transactions respond in the cycle after accept.
// Throughput: one transaction at a time; the descent reads one tree level per cycle
//   through the count memory's registered read port.
// Reset: clears the controller and the fill and present counts. Tree entries beyond
//   the fill count read as zero, so no memory clearing pass is needed.
`timescale 1ns / 1ps

module kth_remaining_removal_core #(
   parameter int CAPACITY    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [VALUE_WIDTH-1:0]        req_append_value,
   input  logic [$clog2(CAPACITY+1)-1:0] req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [VALUE_WIDTH-1:0]        rsp_removed_value,
   output logic [$clog2(CAPACITY)-1:0]   rsp_removed_slot,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_remaining_count,
   output logic [1:0]                    rsp_status
);

   kthrr_pkg::ctl_cmd_type cmd;
   kthrr_pkg::dp_stat_type stat;

   kthrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   kthrr_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_append_value    (req_append_value),
      .req_position        (req_position),
      .rsp_removed_value   (rsp_removed_value),
      .rsp_removed_slot    (rsp_removed_slot),
      .rsp_remaining_count (rsp_remaining_count),
      .rsp_status          (rsp_status)
   );

endmodule
